// ----- sv/nfp_pkg.sv -----
// Shared types and constants for the NMEA field number parser.
package nfp_pkg;

  // ASCII characters the parser reacts to
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Field limits
  localparam logic [2:0] MaxFraction   = 3'd5;
  localparam logic [4:0] MaxFieldIndex = 5'd31;
  localparam logic [2:0] FracLimitRst  = 3'd5;

  // Queue between front and back
  localparam int QueueDepth = 2;

  // Widths of the stream payloads
  localparam int InDataW  = 8;
  localparam int OutDataW = 72;
  localparam int OutUserW = 4;

  // Character classes produced by the front end
  typedef enum logic [2:0] {
    CLS_DOLLAR,
    CLS_COMMA,
    CLS_STAR,
    CLS_ILLEGAL,
    CLS_MINUS,
    CLS_POINT,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  // Field termination codes
  typedef enum logic [1:0] {
    END_COMMA   = 2'd0,
    END_STAR    = 2'd1,
    END_ILLEGAL = 2'd2
  } end_kind_e;

  // One classified character
  typedef struct packed {
    char_class_e cls;
    logic [7:0]  ch;
    logic [3:0]  digit;
  } token_t;

endpackage

// ----- sv/nmea_field_number_parser_core.sv -----
// NMEA field number parser: one character per cycle in while results are taken, one item per closed field out.
// A closing character is stored in the queue, then its result item is built in the result register.
// Throughput: one character per cycle; the back end's combinational multiply-by-ten
// accumulate and the two-entry queue sustain that while the result port keeps up.
// Reset: asynchronous, active low; clears sentence state, queue and result valid,
// and sets fraction_limit to 5.
module nmea_field_number_parser_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: fraction_limit
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [nfp_pkg::InDataW-1:0] s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [4:0] field_index, [36:5] field_value, [39:37] decimals,
  // [47:40] first_char, [71:48] sentence_tag
  output logic [nfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] is_empty, [1] not_numeric, [3:2] end_kind
  output logic [nfp_pkg::OutUserW-1:0] m_axis_tuser_o
);

  logic            fr_valid, fr_ready;
  nfp_pkg::token_t fr_tok;
  logic            bk_valid, bk_ready;
  nfp_pkg::token_t bk_tok;

  // Front end: classify
  nfp_classify u_classify (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .tok_valid_o     (fr_valid),
    .tok_ready_i     (fr_ready),
    .tok_o           (fr_tok)
  );

  // Decoupling queue
  nfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_tok_i   (fr_tok),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_tok_o    (bk_tok)
  );

  // Back end: field state and result
  nfp_execute u_execute (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .tok_valid_i     (bk_valid),
    .tok_ready_o     (bk_ready),
    .tok_i           (bk_tok),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- sv/nfp_classify.sv -----
// Front end: sorts each received character into a class for the back end.
module nfp_classify (
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [nfp_pkg::InDataW-1:0] s_axis_tdata_i,  // [7:0] rx_byte
  output logic                      tok_valid_o,
  input  logic                      tok_ready_i,
  output nfp_pkg::token_t           tok_o
);

  logic [7:0] ch;

  assign ch = s_axis_tdata_i;

  // Handshake passes straight through to the queue
  assign tok_valid_o     = s_axis_tvalid_i;
  assign s_axis_tready_o = tok_ready_i;

  // Class decode
  always_comb begin
    tok_o.ch    = ch;
    tok_o.digit = 4'(ch - nfp_pkg::ChZero);
    if (ch == nfp_pkg::ChDollar) begin
      tok_o.cls = nfp_pkg::CLS_DOLLAR;
    end else if (ch == nfp_pkg::ChComma) begin
      tok_o.cls = nfp_pkg::CLS_COMMA;
    end else if (ch == nfp_pkg::ChStar) begin
      tok_o.cls = nfp_pkg::CLS_STAR;
    end else if (ch < nfp_pkg::ChSpace || ch > nfp_pkg::ChLowerZ) begin
      tok_o.cls = nfp_pkg::CLS_ILLEGAL;
    end else if (ch == nfp_pkg::ChMinus) begin
      tok_o.cls = nfp_pkg::CLS_MINUS;
    end else if (ch == nfp_pkg::ChPoint) begin
      tok_o.cls = nfp_pkg::CLS_POINT;
    end else if (ch >= nfp_pkg::ChZero && ch <= nfp_pkg::ChNine) begin
      tok_o.cls = nfp_pkg::CLS_DIGIT;
    end else begin
      tok_o.cls = nfp_pkg::CLS_OTHER;
    end
  end

endmodule

// ----- sv/nfp_queue.sv -----
// Short register queue of classified characters between front and back.
module nfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  nfp_pkg::token_t push_tok_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output nfp_pkg::token_t pop_tok_o
);

  localparam int PtrW = (nfp_pkg::QueueDepth > 1) ? $clog2(nfp_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(nfp_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(nfp_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(nfp_pkg::QueueDepth - 1);

  nfp_pkg::token_t entry_q [nfp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != DepthC);
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ----- sv/nfp_execute.sv -----
// Back end: field state, number accumulation and the registered result item.
module nfp_execute (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_wdata_i,
  input  logic                        tok_valid_i,
  output logic                        tok_ready_o,
  input  nfp_pkg::token_t             tok_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [nfp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [nfp_pkg::OutUserW-1:0] m_axis_tuser_o
);

  // Sentence and field state
  logic        in_sent_q, in_sent_d;
  logic [4:0]  fcount_q, fcount_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  frac_q, frac_d;
  logic        point_q, point_d;
  logic        neg_q, neg_d;
  logic        bad_q, bad_d;
  logic        started_q, started_d;
  logic [7:0]  lead_q, lead_d;
  logic [23:0] tail_q, tail_d;
  logic [2:0]  frac_lim_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [nfp_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic [nfp_pkg::OutUserW-1:0] out_user_q, out_user_d;

  logic        take;
  logic [2:0]  limit;
  logic [31:0] acc_step;
  logic [31:0] signed_val;
  logic        zero_val;
  logic        emit;
  nfp_pkg::end_kind_e kind;

  assign tok_ready_o     = !out_valid_q || m_axis_tready_i;
  assign take            = tok_valid_i && tok_ready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  assign limit      = (frac_lim_q > nfp_pkg::MaxFraction) ? nfp_pkg::MaxFraction : frac_lim_q;
  assign acc_step   = (acc_q << 3) + (acc_q << 1) + 32'(tok_i.digit);
  assign signed_val = neg_q ? (32'd0 - acc_q) : acc_q;
  assign zero_val   = bad_q || !started_q;

  // Per-character state update
  always_comb begin
    in_sent_d = in_sent_q;
    fcount_d  = fcount_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    point_d   = point_q;
    neg_d     = neg_q;
    bad_d     = bad_q;
    started_d = started_q;
    lead_d    = lead_q;
    tail_d    = tail_q;
    emit      = 1'b0;
    kind      = nfp_pkg::END_COMMA;
    if (take) begin
      if (tok_i.cls == nfp_pkg::CLS_DOLLAR) begin
        in_sent_d = 1'b1;
        fcount_d  = '0;
        tail_d    = '0;
        acc_d     = '0;
        frac_d    = '0;
        point_d   = 1'b0;
        neg_d     = 1'b0;
        bad_d     = 1'b0;
        started_d = 1'b0;
        lead_d    = '0;
      end else if (in_sent_q) begin
        case (tok_i.cls)
          nfp_pkg::CLS_COMMA, nfp_pkg::CLS_STAR, nfp_pkg::CLS_ILLEGAL: begin
            emit = 1'b1;
            if (tok_i.cls == nfp_pkg::CLS_COMMA) begin
              kind = nfp_pkg::END_COMMA;
              if (fcount_q < nfp_pkg::MaxFieldIndex) begin
                fcount_d = fcount_q + 1'b1;
              end
            end else begin
              kind = (tok_i.cls == nfp_pkg::CLS_STAR) ? nfp_pkg::END_STAR
                                                      : nfp_pkg::END_ILLEGAL;
              in_sent_d = 1'b0;
            end
            acc_d     = '0;
            frac_d    = '0;
            point_d   = 1'b0;
            neg_d     = 1'b0;
            bad_d     = 1'b0;
            started_d = 1'b0;
            lead_d    = '0;
          end
          default: begin
            // ordinary field character
            if (fcount_q == '0) begin
              tail_d = {tail_q[15:0], tok_i.ch};
            end
            case (tok_i.cls)
              nfp_pkg::CLS_MINUS: begin
                if (!started_q) begin
                  neg_d = 1'b1;
                end else begin
                  bad_d = 1'b1;
                end
              end
              nfp_pkg::CLS_POINT: begin
                if (point_q) begin
                  bad_d = 1'b1;
                end
                point_d = 1'b1;
              end
              nfp_pkg::CLS_DIGIT: begin
                if (!point_q) begin
                  acc_d = acc_step;
                end else if (frac_q < limit) begin
                  acc_d  = acc_step;
                  frac_d = frac_q + 1'b1;
                end
              end
              default: begin
                bad_d = 1'b1;
              end
            endcase
            if (!started_q) begin
              started_d = 1'b1;
              lead_d    = tok_i.ch;
            end
          end
        endcase
      end
    end
  end

  // Result item assembly
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = {tail_q,
                     started_q ? lead_q : 8'd0,
                     zero_val ? 3'd0 : frac_q,
                     zero_val ? 32'd0 : signed_val,
                     fcount_q};
      out_user_d  = {kind, bad_q, !started_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q   <= 1'b0;
      fcount_q    <= '0;
      acc_q       <= '0;
      frac_q      <= '0;
      point_q     <= 1'b0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      started_q   <= 1'b0;
      lead_q      <= '0;
      tail_q      <= '0;
      frac_lim_q  <= nfp_pkg::FracLimitRst;
      out_valid_q <= 1'b0;
    end else begin
      in_sent_q   <= in_sent_d;
      fcount_q    <= fcount_d;
      acc_q       <= acc_d;
      frac_q      <= frac_d;
      point_q     <= point_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      started_q   <= started_d;
      lead_q      <= lead_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        frac_lim_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule
